>>> rtl/mld_pkg.sv
`timescale 1ns / 1ps
package mld_pkg;

  // Angle units of 1/256 degree
  localparam int unsigned FullTurn    = 92160;
  localparam int unsigned QuarterTurn = 23040;
  localparam int unsigned HalfTurn    = 46080;
  localparam int unsigned ThreeQuarter = 69120;

  // Offset that keeps the yaw sum positive before the wrap: FullTurn * 2^12
  localparam logic [30:0] WRAP_OFFSET = 31'd377487360;
  localparam int unsigned WRAP_STEPS  = 14;

  // Serial multiply lengths
  localparam int unsigned SENS_W   = 12;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned CW       = 33;
  localparam int unsigned PW       = 2 * CW;

  // Rotation constants
  localparam int unsigned ROT_STEPS = 16;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [24:0] ATAN_TAB [ROT_STEPS] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
    25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
    25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
    25'sd917,     25'sd458,     25'sd229,    25'sd115
  };

  // Register indexes
  localparam logic [7:0] REG_SENSITIVITY = 8'd0;
  localparam logic [7:0] REG_PITCH_LIMIT = 8'd1;

  // Reset values
  localparam logic [SENS_W-1:0]  SENS_RESET  = 12'd128;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd22784;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_WRAP,
    ST_SETUP,
    ST_ROT,
    ST_MAP,
    ST_PROD,
    ST_DONE
  } state_e;

endpackage

>>> rtl/mld_if.sv
`timescale 1ns / 1ps
interface mld_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  modport source (output valid, pos_x, pos_y, input ready);
  modport sink (input valid, pos_x, pos_y, output ready);
endinterface

interface mld_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [16:0]        yaw_out;
  logic signed [15:0] pitch_out;
  modport source (output valid, dir_x, dir_y, dir_z, yaw_out, pitch_out, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, yaw_out, pitch_out, output ready);
endinterface

interface mld_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/mouse_look_direction.sv
`timescale 1ns / 1ps
// Sequence: request accept, 12-bit gain multiply, 14 yaw wrap steps, 16 rotation
//   steps, 33 product steps and control states; a stalled result holds in ST_DONE.
// Requests: one at a time; a new request is taken only in ST_IDLE, after the result
//   is loaded; the serial product of the two 33-bit cosine/sine words is the longest phase.
// Reset: async active low; angles and last position clear, first-sample flag
//   sets, sensitivity 128 and pitch limit 22784 load.
module mouse_look_direction (
  input  logic          clk_i,
  input  logic          rst_ni,
  mld_req_if.sink       req_i,
  mld_rsp_if.source     rsp_o,
  mld_cfg_if.sink       cfg_i
);
  import mld_pkg::*;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  logic [SENS_W-1:0]  sens_q;
  logic [LIMIT_W-1:0] limit_q;
  logic signed [15:0] last_x_q, last_y_q;
  logic               first_q;
  logic [16:0]        yaw_q;
  logic signed [15:0] pitch_q;
  logic               rsp_valid_q;

  logic signed [28:0] mul_acc_q [2];
  logic signed [28:0] mul_mc_q [2];
  logic [SENS_W-1:0]  sens_sh_q;
  logic [29:0]        wrap_q;

  logic signed [CW-1:0] x_q [2];
  logic signed [CW-1:0] y_q [2];
  logic signed [24:0]   z_q [2];
  logic [1:0]           quad_q [2];

  logic signed [PW-1:0] prod_q [2];
  logic signed [PW-1:0] pmc_q [2];
  logic [CW-1:0]        cp_sh_q;
  logic signed [CW-1:0] sp_q;

  logic signed [15:0] dir_x_q, dir_y_q, dir_z_q;
  logic [16:0]        yaw_out_q;
  logic signed [15:0] pitch_out_q;

  logic signed [16:0] dx, dy;
  logic signed [30:0] wrap_sum;
  logic signed [29:0] pitch_sum, lim_s;
  logic [15:0]        lim;
  logic [29:0]        wrap_thr;
  logic [16:0]        ang [2];
  logic [1:0]         quad [2];
  logic [16:0]        rem [2];
  logic signed [CW-1:0] x_d [2];
  logic signed [CW-1:0] y_d [2];
  logic signed [24:0]   z_d [2];
  logic signed [CW-1:0] cos_m [2];
  logic signed [CW-1:0] sin_m [2];
  logic signed [33:0]   ry;
  logic signed [PW-1:0] rx, rz;
  logic                 req_acc, rsp_load;

  function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
    if (v > 66'sd32767) return 16'sd32767;
    else if (v < -66'sd32768) return -16'sd32768;
    else return v[15:0];
  endfunction

  assign req_acc  = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);

  // Pointer deltas; the first sample seeds the last position
  assign dx = first_q ? 17'sd0 : 17'(req_i.pos_x) - 17'(last_x_q);
  assign dy = first_q ? 17'sd0 : 17'(last_y_q) - 17'(req_i.pos_y);

  // Angle sums and clamp
  assign wrap_sum  = $signed({14'd0, yaw_q}) + 31'(mul_acc_q[0]) + $signed(WRAP_OFFSET);
  assign lim       = (limit_q > 15'(QuarterTurn)) ? 16'(QuarterTurn) : {1'b0, limit_q};
  assign lim_s     = $signed({14'd0, lim});
  assign pitch_sum = 30'(pitch_q) + 30'(mul_acc_q[1]);
  assign wrap_thr  = 30'(FullTurn) << cnt_q[3:0];

  // Split angles into quadrant and remainder
  assign ang[0] = wrap_q[16:0];
  assign ang[1] = pitch_q[15] ? 17'(pitch_q) + 17'(FullTurn) : 17'(pitch_q);
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (ang[i] >= 17'(ThreeQuarter)) begin
        quad[i] = 2'd3; rem[i] = ang[i] - 17'(ThreeQuarter);
      end else if (ang[i] >= 17'(HalfTurn)) begin
        quad[i] = 2'd2; rem[i] = ang[i] - 17'(HalfTurn);
      end else if (ang[i] >= 17'(QuarterTurn)) begin
        quad[i] = 2'd1; rem[i] = ang[i] - 17'(QuarterTurn);
      end else begin
        quad[i] = 2'd0; rem[i] = ang[i];
      end
    end
  end

  // One rotation step per unit
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (!z_q[i][24]) begin
        x_d[i] = x_q[i] - (y_q[i] >>> cnt_q[3:0]);
        y_d[i] = y_q[i] + (x_q[i] >>> cnt_q[3:0]);
        z_d[i] = z_q[i] - ATAN_TAB[cnt_q[3:0]];
      end else begin
        x_d[i] = x_q[i] + (y_q[i] >>> cnt_q[3:0]);
        y_d[i] = y_q[i] - (x_q[i] >>> cnt_q[3:0]);
        z_d[i] = z_q[i] + ATAN_TAB[cnt_q[3:0]];
      end
    end
  end

  // Map quadrant by sign swaps
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      case (quad_q[i])
        2'd0: begin cos_m[i] = x_q[i];  sin_m[i] = y_q[i];  end
        2'd1: begin cos_m[i] = -y_q[i]; sin_m[i] = x_q[i];  end
        2'd2: begin cos_m[i] = -x_q[i]; sin_m[i] = -y_q[i]; end
        default: begin cos_m[i] = y_q[i]; sin_m[i] = -x_q[i]; end
      endcase
    end
  end

  // Round to Q1.15
  assign ry = (34'(sp_q) + 34'sd16384) >>> 15;
  assign rx = (prod_q[0] + (66'sd1 <<< 44)) >>> 45;
  assign rz = (prod_q[1] + (66'sd1 <<< 44)) >>> 45;

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: if (req_acc) begin
        state_d = ST_MUL; cnt_d = '0;
      end
      ST_MUL: if (cnt_q == 6'(SENS_W - 1)) state_d = ST_SUM;
              else cnt_d = cnt_q + 6'd1;
      ST_SUM: begin
        state_d = ST_WRAP; cnt_d = 6'(WRAP_STEPS - 1);
      end
      ST_WRAP: if (cnt_q == '0) state_d = ST_SETUP;
               else cnt_d = cnt_q - 6'd1;
      ST_SETUP: begin
        state_d = ST_ROT; cnt_d = '0;
      end
      ST_ROT: if (cnt_q == 6'(ROT_STEPS - 1)) state_d = ST_MAP;
              else cnt_d = cnt_q + 6'd1;
      ST_MAP: begin
        state_d = ST_PROD; cnt_d = '0;
      end
      ST_PROD: if (cnt_q == 6'(CW - 1)) state_d = ST_DONE;
               else cnt_d = cnt_q + 6'd1;
      ST_DONE: if (rsp_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req_i.ready     = (state_q == ST_IDLE);
    cfg_i.ready     = 1'b1;
    rsp_o.valid     = rsp_valid_q;
    rsp_o.dir_x     = dir_x_q;
    rsp_o.dir_y     = dir_y_q;
    rsp_o.dir_z     = dir_z_q;
    rsp_o.yaw_out   = yaw_out_q;
    rsp_o.pitch_out = pitch_out_q;
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sens_q      <= SENS_RESET;
      limit_q     <= LIMIT_RESET;
      last_x_q    <= '0;
      last_y_q    <= '0;
      first_q     <= 1'b1;
      yaw_q       <= '0;
      pitch_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_SENSITIVITY) sens_q <= cfg_i.data[SENS_W-1:0];
        else if (cfg_i.index == REG_PITCH_LIMIT) limit_q <= cfg_i.data[LIMIT_W-1:0];
      end
      if (req_acc) begin
        last_x_q <= req_i.pos_x;
        last_y_q <= req_i.pos_y;
        first_q  <= 1'b0;
      end
      if (state_q == ST_SUM) begin
        if (pitch_sum > lim_s) pitch_q <= 16'(lim_s);
        else if (pitch_sum < -lim_s) pitch_q <= 16'(-lim_s);
        else pitch_q <= 16'(pitch_sum);
      end
      if (state_q == ST_SETUP) yaw_q <= wrap_q[16:0];
      if (rsp_load) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (req_acc) begin
        mul_mc_q[0]  <= 29'(dx);
        mul_mc_q[1]  <= 29'(dy);
        mul_acc_q[0] <= '0;
        mul_acc_q[1] <= '0;
        sens_sh_q    <= sens_q;
      end
      ST_MUL: begin
        for (int i = 0; i < 2; i++) begin
          if (sens_sh_q[0]) mul_acc_q[i] <= mul_acc_q[i] + mul_mc_q[i];
          mul_mc_q[i] <= mul_mc_q[i] <<< 1;
        end
        sens_sh_q <= sens_sh_q >> 1;
      end
      ST_SUM: wrap_q <= wrap_sum[29:0];
      ST_WRAP: if (wrap_q >= wrap_thr) wrap_q <= wrap_q - wrap_thr;
      ST_SETUP: begin
        for (int i = 0; i < 2; i++) begin
          x_q[i]    <= CORDIC_GAIN;
          y_q[i]    <= '0;
          z_q[i]    <= $signed({2'b00, rem[i][14:0], 8'd0});
          quad_q[i] <= quad[i];
        end
      end
      ST_ROT: begin
        for (int i = 0; i < 2; i++) begin
          x_q[i] <= x_d[i];
          y_q[i] <= y_d[i];
          z_q[i] <= z_d[i];
        end
      end
      ST_MAP: begin
        pmc_q[0]  <= PW'(cos_m[0]);
        pmc_q[1]  <= PW'(sin_m[0]);
        prod_q[0] <= '0;
        prod_q[1] <= '0;
        cp_sh_q   <= cos_m[1];
        sp_q      <= sin_m[1];
      end
      ST_PROD: begin
        for (int i = 0; i < 2; i++) begin
          if (cp_sh_q[0]) begin
            if (cnt_q == 6'(CW - 1)) prod_q[i] <= prod_q[i] - pmc_q[i];
            else prod_q[i] <= prod_q[i] + pmc_q[i];
          end
          pmc_q[i] <= pmc_q[i] <<< 1;
        end
        cp_sh_q <= cp_sh_q >> 1;
      end
      ST_DONE: if (rsp_load) begin
        dir_x_q     <= sat16(rx);
        dir_y_q     <= sat16(PW'(ry));
        dir_z_q     <= sat16(rz);
        yaw_out_q   <= yaw_q;
        pitch_out_q <= pitch_q;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.yaw_out < 17'd92160))
    else $error("yaw out of range");
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.pitch_out <= 16'sd23040 && rsp_o.pitch_out >= -16'sd23040))
    else $error("pitch out of range");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while busy");
`endif

endmodule

>>> verif/mld_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces come from the RTL tree. This file holds only
// the view-direction expectation record that the scoreboard and the tasks share.
package mld_tb_pkg;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [16:0]        yaw;
    logic signed [15:0] pitch;
  } view_t;

endpackage

>>> verif/mouse_look_direction_test.sv
`timescale 1ns / 1ps
module mouse_look_direction_test;
  import mld_pkg::*;
  import mld_tb_pkg::*;

  localparam int LATENCY = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatches = 0;
  bit   calm = 1'b0;
  int   hold_off = 0;

  mld_req_if req ();
  mld_rsp_if rsp ();
  mld_cfg_if cfg ();

  mouse_look_direction dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req.sink),
    .rsp_o (rsp.source),
    .cfg_i (cfg.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("mouse_look_direction_test: FAIL");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  // Scoreboard: mirrors the pointer-look state and queues expected views
  class view_board;
    logic [11:0]        sens;
    logic [14:0]        limit;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    bit                 seed_pending;
    int                 yaw;
    int                 pitch;
    view_t              pending[$];

    function new();
      sens = SENS_RESET;
      limit = LIMIT_RESET;
      prev_x = 0;
      prev_y = 0;
      seed_pending = 1'b1;
      yaw = 0;
      pitch = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] val);
      if (idx == REG_SENSITIVITY) sens = val[11:0];
      else if (idx == REG_PITCH_LIMIT) limit = val[14:0];
    endfunction

    // Run the rotation and fold the quadrant back in; cos/sin in Q1.30
    function automatic void rotate(int ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      int q;
      q = ang / 23040;
      x = 652032874;
      y = 0;
      z = longint'(ang % 23040) * 256;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_TAB[i];
        end else begin
          x += dx; y -= dy; z += ATAN_TAB[i];
        end
      end
      case (q & 3)
        0: begin c = x; s = y; end
        1: begin c = -y; s = x; end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function automatic logic signed [15:0] to_q15(longint v, int sh);
      longint r;
      r = (v + (longint'(1) << (sh - 1))) >>> sh;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_request(logic signed [15:0] px, logic signed [15:0] py);
      longint v, lim, cy, sy, cp, sp;
      view_t e;
      if (seed_pending) begin
        prev_x = px;
        prev_y = py;
        seed_pending = 1'b0;
      end
      v = (longint'(yaw) + (longint'(px) - prev_x) * longint'(sens)) % 92160;
      if (v < 0) v += 92160;
      yaw = int'(v);
      lim = (limit > 23040) ? 23040 : limit;
      v = longint'(pitch) + (longint'(prev_y) - py) * longint'(sens);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      pitch = int'(v);
      prev_x = px;
      prev_y = py;
      rotate(yaw, cy, sy);
      rotate(pitch < 0 ? pitch + 92160 : pitch, cp, sp);
      e.dir_x = to_q15(cy * cp, 45);
      e.dir_y = to_q15(sp, 15);
      e.dir_z = to_q15(sy * cp, 45);
      e.yaw = yaw[16:0];
      e.pitch = pitch[15:0];
      pending = {pending, e};
    endfunction

    task check_view(view_t got);
      view_t w;
      if (pending.size() == 0) begin
        report("unexpected view", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (got.dir_x !== w.dir_x) report("dir_x", got.dir_x, w.dir_x);
      if (got.dir_y !== w.dir_y) report("dir_y", got.dir_y, w.dir_y);
      if (got.dir_z !== w.dir_z) report("dir_z", got.dir_z, w.dir_z);
      if (got.yaw !== w.yaw) report("yaw_out", got.yaw, w.yaw);
      if (got.pitch !== w.pitch) report("pitch_out", got.pitch, w.pitch);
    endtask
  endclass

  view_board board = new();

  // Note requests and check views at the rising edge
  always @(posedge clk_i) begin
    view_t got;
    if (rst_ni && req.valid && req.ready) board.note_request(req.pos_x, req.pos_y);
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{rsp.dir_x, rsp.dir_y, rsp.dir_z, rsp.yaw_out, rsp.pitch_out};
      board.check_view(got);
    end
  end

  // Drive the result ready with random stall bursts and long hold-offs
  initial begin
    int gap;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        rsp.ready <= 1'b0;
        hold_off--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 13);
        rsp.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Offer one request; valid stays up afterwards until the next request or a pause
  task automatic send_pos(input logic signed [15:0] px, input logic signed [15:0] py);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.pos_x <= px;
    req.pos_y <= py;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    req.valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (LATENCY + 20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly small moves so pitch wanders, with occasional full-range jumps
  task automatic random_walk(input int n);
    logic signed [15:0] x, y;
    x = 16'($urandom);
    y = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'(int'(x) + int'($urandom_range(0, 400)) - 200);
        y = 16'(int'(y) + int'($urandom_range(0, 400)) - 200);
      end
      send_pos(x, y);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.pos_x = '0;
    req.pos_y = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: first sample at the extremes, then opposite corners
    send_pos(16'sh7FFF, -16'sh8000);
    send_pos(-16'sh8000, 16'sh7FFF);
    send_pos(16'sh7FFF, -16'sh8000);
    send_pos(0, 0);
    send_pos(-100, 50);
    send_pos(-300, 400);
    send_pos(200, -1000);
    drain();
    write_reg(REG_SENSITIVITY, 16'd4095);
    write_reg(REG_PITCH_LIMIT, 16'd32767);
    send_pos(-16'sh8000, -16'sh8000);
    send_pos(16'sh7FFF, 16'sh7FFF);
    send_pos(-16'sh8000, -16'sh8000);
    send_pos(1, 1);
    drain();
    write_reg(REG_PITCH_LIMIT, 16'd0);
    write_reg(8'd7, 16'hFFFF);
    send_pos(40, 3);
    send_pos(-40, -3);
    drain();
    write_reg(REG_SENSITIVITY, 16'd0);
    write_reg(REG_PITCH_LIMIT, 16'd23040);
    send_pos(1234, -4321);
    send_pos(-9, 9);
    drain();

    // Random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SENSITIVITY, (ph == 0) ? 16'd128 : 16'($urandom_range(0, 4095)));
      write_reg(REG_PITCH_LIMIT, (ph == 1) ? 16'd23040 : 16'($urandom_range(0, 32767)));
      if (ph == 2) hold_off = 600;
      random_walk(270);
      drain();
    end

    // Final stretch without idling
    calm = 1'b1;
    random_walk(200);
    drain();

    if (mismatches == 0 && board.pending.size() == 0) begin
      $display("mouse_look_direction_test: PASS");
    end else begin
      $display("mouse_look_direction_test: FAIL");
    end
    $finish;
  end

endmodule
